FILE: rtl/core/vp8pk_pkg.sv
// ----------------------------------------------------------------------------
// VP8 RTP payload packetizer package
// Request types, register indexes and descriptor constants shared by the
// packetizer RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package vp8pk_pkg;

  localparam int unsigned MaxPktW  = 14;
  localparam int unsigned PicIdW   = 15;
  localparam int unsigned CfgDataW = 15;

  // Configuration register indexes.
  localparam logic CFG_MAX_PKT_SIZE = 1'b0;
  localparam logic CFG_PIC_ID_SEED  = 1'b1;

  localparam logic [MaxPktW-1:0] MAX_PKT_SIZE_RST = 14'd1300;
  localparam logic [PicIdW-1:0]  PIC_ID_RST       = 15'd0;

  // Descriptor bytes.
  localparam logic [7:0] DESC_X_START = 8'h90;
  localparam logic [7:0] DESC_X_CONT  = 8'h80;
  localparam logic [7:0] DESC_I       = 8'h80;
  localparam logic [PicIdW-1:0] PIC_ID_SHORT_LIMIT = 15'd128;

  // Descriptor byte positions.
  localparam logic [1:0] HDR_BYTE0  = 2'd0;
  localparam logic [1:0] HDR_BYTE1  = 2'd1;
  localparam logic [1:0] HDR_PID_HI = 2'd2;
  localparam logic [1:0] HDR_PID_LO = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       packet_end;
    logic       frame_done;
    logic       run_last;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/vp8_rtp_payload_packetizer.sv
// ----------------------------------------------------------------------------
// VP8 RTP payload packetizer
// Cuts a byte stream of encoded VP8 frames into RTP payloads, each opened by
// a VP8 payload descriptor.
// ----------------------------------------------------------------------------
// Usage: the encoder offers one frame byte per request on the input channel
// (in_valid_i / in_stall_o), with frame_end set on the frame's last byte.
// The block returns one payload byte per request on the output channel
// (out_valid_o / out_stall_i), descriptor bytes flagged by is_header.
// An accepted byte sits in an input register; the byte stream then moves
// through one output register. Data bytes flow at one per cycle unless
// stalled. A byte that opens a payload waits for a descriptor of 3 bytes
// (4 when the picture id is 128 or more), since the single output register
// emits at most one byte per cycle. While the receiver stalls, the output
// register holds its request and the input register fills, after which
// in_stall_o is raised. Configuration writes (cfg_we_i) take effect at once;
// the user must do them only while the block is empty, as the block does
// not enforce it. Reset empties both registers, sets the size limit to 1300
// and the picture id to 0, and starts a new frame.
// ----------------------------------------------------------------------------
`default_nettype none

module vp8_rtp_payload_packetizer (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire                              cfg_idx_i,
  input  wire  [vp8pk_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  vp8pk_pkg::in_item_t        in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output vp8pk_pkg::out_item_t             out_data_o
);

  logic [vp8pk_pkg::MaxPktW-1:0] max_pkt_q;
  logic [vp8pk_pkg::PicIdW-1:0]  pic_id_q;
  logic                          first_of_frame_q;
  logic                          at_pkt_start_q;
  logic [vp8pk_pkg::MaxPktW-1:0] pay_cnt_q;
  logic [1:0]                    hdr_idx_q;

  logic                 in_vld_q;
  vp8pk_pkg::in_item_t  in_q;
  logic                 out_vld_q;
  vp8pk_pkg::out_item_t out_q;

  logic                          emit;
  logic                          data_fire;
  logic                          pid_short;
  logic [1:0]                    hdr_last_idx;
  logic [vp8pk_pkg::MaxPktW-1:0] cnt_inc;
  logic                          pend;
  logic [7:0]                    hdr_byte;
  vp8pk_pkg::out_item_t          out_d;
  logic                          in_accept;

  assign emit      = in_vld_q && (!out_vld_q || !out_stall_i);
  assign data_fire = emit && !at_pkt_start_q;
  assign in_stall_o = in_vld_q && !data_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pid_short    = pic_id_q < vp8pk_pkg::PIC_ID_SHORT_LIMIT;
  assign hdr_last_idx = pid_short ? vp8pk_pkg::HDR_PID_HI : vp8pk_pkg::HDR_PID_LO;
  assign cnt_inc      = pay_cnt_q + {{(vp8pk_pkg::MaxPktW-1){1'b0}}, 1'b1};
  assign pend         = (cnt_inc >= max_pkt_q) || in_q.frame_end;

  always_comb begin
    unique case (hdr_idx_q)
      vp8pk_pkg::HDR_BYTE0: begin
        hdr_byte = first_of_frame_q ? vp8pk_pkg::DESC_X_START : vp8pk_pkg::DESC_X_CONT;
      end
      vp8pk_pkg::HDR_BYTE1: begin
        hdr_byte = vp8pk_pkg::DESC_I;
      end
      vp8pk_pkg::HDR_PID_HI: begin
        hdr_byte = pid_short ? pic_id_q[7:0] : {1'b1, pic_id_q[14:8]};
      end
      default: begin
        hdr_byte = pic_id_q[7:0];
      end
    endcase
  end

  always_comb begin
    if (at_pkt_start_q) begin
      out_d.out_byte   = hdr_byte;
      out_d.is_header  = 1'b1;
      out_d.packet_end = 1'b0;
      out_d.frame_done = 1'b0;
      out_d.run_last   = 1'b0;
    end else begin
      out_d.out_byte   = in_q.data_byte;
      out_d.is_header  = 1'b0;
      out_d.packet_end = pend;
      out_d.frame_done = in_q.frame_end;
      out_d.run_last   = 1'b1;
    end
  end

  // Packetizer state, advanced once per emitted byte; configuration writes load the size limit and picture id.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q        <= vp8pk_pkg::MAX_PKT_SIZE_RST;
      pic_id_q         <= vp8pk_pkg::PIC_ID_RST;
      first_of_frame_q <= 1'b1;
      at_pkt_start_q   <= 1'b1;
      pay_cnt_q        <= '0;
      hdr_idx_q        <= vp8pk_pkg::HDR_BYTE0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == vp8pk_pkg::CFG_MAX_PKT_SIZE)) begin
        max_pkt_q <= cfg_wdata_i[vp8pk_pkg::MaxPktW-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == vp8pk_pkg::CFG_PIC_ID_SEED)) begin
        pic_id_q <= cfg_wdata_i[vp8pk_pkg::PicIdW-1:0];
      end else if (data_fire && in_q.frame_end) begin
        pic_id_q <= pic_id_q + {{(vp8pk_pkg::PicIdW-1){1'b0}}, 1'b1};
      end

      if (emit && at_pkt_start_q) begin
        if (hdr_idx_q == hdr_last_idx) begin
          at_pkt_start_q   <= 1'b0;
          first_of_frame_q <= 1'b0;
          hdr_idx_q        <= vp8pk_pkg::HDR_BYTE0;
          pay_cnt_q        <= {{(vp8pk_pkg::MaxPktW-2){1'b0}}, hdr_idx_q}
                              + {{(vp8pk_pkg::MaxPktW-1){1'b0}}, 1'b1};
        end else begin
          hdr_idx_q <= hdr_idx_q + 2'd1;
        end
      end else if (data_fire) begin
        if (pend) begin
          at_pkt_start_q <= 1'b1;
          pay_cnt_q      <= '0;
        end else begin
          pay_cnt_q <= cnt_inc;
        end
        if (in_q.frame_end) begin
          first_of_frame_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (data_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Once the descriptor is out, the count already includes its bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !at_pkt_start_q |-> (pay_cnt_q >= 14'd3))
    else $error("payload count below descriptor length in data phase");

  // A byte that closes a payload makes the next byte open a new descriptor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_fire && pend) |=> (at_pkt_start_q && (hdr_idx_q == vp8pk_pkg::HDR_BYTE0)))
    else $error("payload end did not restart the descriptor");

  // The frame's last byte always closes its payload and its input's run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.frame_done) |-> (out_q.packet_end && out_q.run_last))
    else $error("frame end byte without payload end");

endmodule

`default_nettype wire
